// ----- src/wcht_pkg.sv -----
`timescale 1ns / 1ps

package wcht_pkg;

   // default geometry of the table
   localparam int DEF_BUCKETS     = 1024;
   localparam int DEF_WAYS        = 4;
   localparam int DEF_MAX_LETTERS = 10;
   localparam int DEF_COUNT_BITS  = 20;

   // letter coding and field widths
   localparam int LETTER_W = 5;
   localparam int LEN_W    = 4;
   localparam int STATUS_W = 2;
   localparam logic [LETTER_W-1:0] ALPHABET = 5'd26;

   // request operations
   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   // response status codes
   localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd3;

endpackage

// ----- src/word_count_hash_table.sv -----
`timescale 1ns / 1ps

// Word occurrence counter on a set-associative hash table. A request either adds one
// occurrence of a lower-case word (letters coded 0..25, first letter in the low bits)
// or queries its count; every request gives exactly one response with the count and a
// status (ok, bucket full, count saturated, invalid word). The word is hashed by its
// base-26 value modulo BUCKETS, one letter per cycle through a multiply-by-26 and
// reduce unit, then its bucket row (WAYS slots of valid, key and count) is read from a
// single-port synchronous memory, compared, and written back when the output
// register is free. A request thus passes acceptance, one hashing step per letter,
// memory read, and compare and write-back before its response is registered; one
// with an invalid length goes from acceptance straight to compare. One request is
// in flight at a time; the next one is accepted while the previous response still
// waits in the output register. After reset the block clears the BUCKETS rows of
// the memory, one bucket row per cycle, during which req_stall stays high.

module word_count_hash_table
   import wcht_pkg::*;
#(
   parameter int BUCKETS     = DEF_BUCKETS,
   parameter int WAYS        = DEF_WAYS,
   parameter int MAX_LETTERS = DEF_MAX_LETTERS,
   parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
   input  logic                            clock,
   input  logic                            reset,

   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_opcode,
   input  logic [LETTER_W*MAX_LETTERS-1:0] req_word_letters,
   input  logic [LEN_W-1:0]                req_word_length,

   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [COUNT_BITS-1:0]           rsp_word_count,
   output logic [STATUS_W-1:0]             rsp_status
);

   // derived widths
   localparam int LET_W   = LETTER_W * MAX_LETTERS;
   localparam int KEY_W   = LET_W + LEN_W;
   localparam int ENTRY_W = 1 + KEY_W + COUNT_BITS;
   localparam int ROW_W   = WAYS * ENTRY_W;
   localparam int BW      = $clog2(BUCKETS);
   localparam int TW      = BW + 5;
   localparam logic [TW-1:0] BK = TW'(BUCKETS);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [COUNT_BITS-1:0] COUNT_ONE = COUNT_BITS'(1);

   // sequencer states
   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_HASH   = 3'd2;
   localparam logic [2:0] ST_READ   = 3'd3;
   localparam logic [2:0] ST_LOOKUP = 3'd4;

   // one Horner step: (h * 26 + c) mod BUCKETS, with h < BUCKETS
   function automatic logic [BW-1:0] hash_step(input logic [BW-1:0] h,
                                               input logic [LETTER_W-1:0] c);
      logic [TW-1:0] t;
      t = (TW'({h, 4'b0000}) + TW'({h, 3'b000})) + (TW'({h, 1'b0}) + TW'(c));
      for (int i = 4; i >= 0; i--) begin
         if (t >= (BK << i)) begin
            t = t - (BK << i);
         end
      end
      return t[BW-1:0];
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [BW-1:0]         clr_ff, clr_in;
   logic                  op_ff, op_in;
   logic [LET_W-1:0]      letters_ff, letters_in;
   logic [LEN_W-1:0]      rem_ff, rem_in;
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [BW-1:0]         hash_ff, hash_in;
   logic                  bad_ff, bad_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COUNT_BITS-1:0] rsp_count_ff, rsp_count_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;

   logic [ROW_W-1:0]      bucket_mem [BUCKETS];
   logic [ROW_W-1:0]      rd_row_ff;
   logic [ROW_W-1:0]      wr_row;
   logic [BW-1:0]         wr_addr;
   logic                  mem_we;
   logic                  rd_en;

   logic                  req_acc;
   logic                  out_free;
   logic                  len_bad;
   logic [LET_W-1:0]      masked;
   logic [LETTER_W-1:0]   cur_letter;

   logic [WAYS-1:0]       hit_sel;
   logic [WAYS-1:0]       free_sel;
   logic                  hit_found;
   logic                  free_found;
   logic [COUNT_BITS-1:0] hit_cnt;
   logic                  hit_sat;
   logic                  commit;
   logic                  do_inc;
   logic                  do_new;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_acc    = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign cur_letter = letters_ff[LETTER_W-1:0];
   assign len_bad    = (req_word_length == '0) ||
                       (req_word_length > LEN_W'(MAX_LETTERS));

   // clear letters beyond the word length so the stored key is canonical
   always_comb begin
      for (int k = 0; k < MAX_LETTERS; k++) begin
         masked[k*LETTER_W +: LETTER_W] = (LEN_W'(k) < req_word_length) ?
            req_word_letters[k*LETTER_W +: LETTER_W] : '0;
      end
   end

   // way compare on the bucket row, lowest way wins
   always_comb begin
      logic                  v;
      logic [KEY_W-1:0]      k;
      logic [COUNT_BITS-1:0] c;
      hit_sel    = '0;
      free_sel   = '0;
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_cnt    = '0;
      for (int w = 0; w < WAYS; w++) begin
         v = rd_row_ff[w*ENTRY_W + ENTRY_W - 1];
         k = rd_row_ff[w*ENTRY_W + COUNT_BITS +: KEY_W];
         c = rd_row_ff[w*ENTRY_W +: COUNT_BITS];
         if (v) begin
            if (!hit_found && (k == key_ff)) begin
               hit_found  = 1'b1;
               hit_sel[w] = 1'b1;
               hit_cnt    = c;
            end
         end else if (!free_found) begin
            free_found  = 1'b1;
            free_sel[w] = 1'b1;
         end
      end
   end

   assign hit_sat = (hit_cnt == COUNT_MAX);
   assign commit  = (state_ff == ST_LOOKUP) && out_free;
   assign do_inc  = commit && !bad_ff && (op_ff == OP_ADD) && hit_found && !hit_sat;
   assign do_new  = commit && !bad_ff && (op_ff == OP_ADD) && !hit_found && free_found;

   // write-back row: zero while clearing, else the read row with one slot updated
   always_comb begin
      wr_row = rd_row_ff;
      for (int w = 0; w < WAYS; w++) begin
         if (do_inc && hit_sel[w]) begin
            wr_row[w*ENTRY_W +: COUNT_BITS] = hit_cnt + COUNT_ONE;
         end
         if (do_new && free_sel[w]) begin
            wr_row[w*ENTRY_W +: ENTRY_W] = {1'b1, key_ff, COUNT_ONE};
         end
      end
      if (state_ff == ST_CLEAR) begin
         wr_row = '0;
      end
   end

   assign mem_we  = (state_ff == ST_CLEAR) || do_inc || do_new;
   assign wr_addr = (state_ff == ST_CLEAR) ? clr_ff : hash_ff;
   assign rd_en   = (state_ff == ST_READ);

   // bucket memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[wr_addr] <= wr_row;
      end
      if (rd_en) begin
         rd_row_ff <= bucket_mem[hash_ff];
      end
   end

   // sequencer and hash datapath
   always_comb begin
      state_in   = state_ff;
      clr_in     = clr_ff;
      op_in      = op_ff;
      letters_in = letters_ff;
      rem_in     = rem_ff;
      key_in     = key_ff;
      hash_in    = hash_ff;
      bad_in     = bad_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + BW'(1);
            if (clr_ff == BW'(BUCKETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               op_in      = req_opcode;
               letters_in = req_word_letters;
               rem_in     = req_word_length;
               key_in     = {req_word_length, masked};
               hash_in    = '0;
               bad_in     = len_bad;
               state_in   = len_bad ? ST_LOOKUP : ST_HASH;
            end
         end
         ST_HASH: begin
            if (cur_letter >= ALPHABET) begin
               bad_in   = 1'b1;
               state_in = ST_LOOKUP;
            end else begin
               hash_in    = hash_step(hash_ff, cur_letter);
               letters_in = letters_ff >> LETTER_W;
               rem_in     = rem_ff - LEN_W'(1);
               if (rem_ff == LEN_W'(1)) begin
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // response register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
         if (bad_ff) begin
            rsp_count_in  = '0;
            rsp_status_in = STATUS_BAD;
         end else if (op_ff == OP_QUERY) begin
            rsp_count_in  = hit_found ? hit_cnt : '0;
            rsp_status_in = STATUS_OK;
         end else if (hit_found) begin
            rsp_count_in  = hit_sat ? COUNT_MAX : hit_cnt + COUNT_ONE;
            rsp_status_in = hit_sat ? STATUS_SAT : STATUS_OK;
         end else if (free_found) begin
            rsp_count_in  = COUNT_ONE;
            rsp_status_in = STATUS_OK;
         end else begin
            rsp_count_in  = '0;
            rsp_status_in = STATUS_FULL;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      letters_ff    <= letters_in;
      rem_ff        <= rem_in;
      key_ff        <= key_in;
      hash_ff       <= hash_in;
      bad_ff        <= bad_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_word_count = rsp_count_ff;
   assign rsp_status     = rsp_status_ff;

   // checks
   a_no_write_on_bad: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOOKUP && bad_ff) |-> !mem_we)
      else $error("table written for an invalid word");

   a_lookup_done: assert property (@(posedge clock) disable iff (reset)
      commit |=> (state_ff == ST_IDLE) && rsp_valid_ff)
      else $error("lookup finished without a registered response");

   a_hash_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (32'(hash_ff) < 32'(BUCKETS)))
      else $error("bucket index out of range");

   a_sat_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == STATUS_SAT) |-> (rsp_count_ff == COUNT_MAX))
      else $error("saturated response without maximum count");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STATUS_FULL || rsp_status_ff == STATUS_BAD))
      |-> (rsp_count_ff == '0))
      else $error("dropped or invalid request with non-zero count");

endmodule

// ----- bench/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import wcht_pkg::*;

   localparam int BUCKETS     = DEF_BUCKETS;
   localparam int WAYS        = DEF_WAYS;
   localparam int MAX_LETTERS = DEF_MAX_LETTERS;
   localparam int COUNT_BITS  = DEF_COUNT_BITS;
   localparam int SLOTS       = BUCKETS * WAYS;
   localparam int WORD_W      = LETTER_W * MAX_LETTERS;
   localparam int KEY_W       = LEN_W + WORD_W;

   localparam int DIRECTED_N   = 24;
   localparam int RANDOM_ITEMS = 1600;
   localparam int POOL_SIZE    = 12;
   localparam int HOLD_AT      = 300;
   localparam int HOLD_CYCLES  = 200;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_MAX   = 50;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

   typedef struct packed {
      logic                  opcode;
      logic [WORD_W-1:0]     word_letters;
      logic [LEN_W-1:0]      word_length;
      logic                  pinned;
      logic [COUNT_BITS-1:0] exp_count;
      logic [STATUS_W-1:0]   exp_status;
   } stim_row_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] word_count;
      logic [STATUS_W-1:0]   status;
   } count_result_type;

   typedef enum int {RSP_FREE, RSP_RANDOM, RSP_PATTERN} rsp_mode_type;

   // directed requests; counts are pinned where they are plain to see
   // count saturation sits a million adds away and is left to the predictor
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_N] = '{
      // query on an empty table misses
      '{OP_QUERY, 50'd0, 4'd1, 1'b1, 20'd0, STATUS_OK},
      // lengths out of range
      '{OP_ADD, 50'd0, 4'd0, 1'b1, 20'd0, STATUS_BAD},
      '{OP_ADD, {50{1'b1}}, 4'd15, 1'b1, 20'd0, STATUS_BAD},
      '{OP_ADD, 50'd0, 4'd11, 1'b1, 20'd0, STATUS_BAD},
      '{OP_QUERY, 50'd0, 4'd12, 1'b1, 20'd0, STATUS_BAD},
      // letter codes above z inside the word
      '{OP_QUERY, {50{1'b1}}, 4'd10, 1'b1, 20'd0, STATUS_BAD},
      '{OP_ADD, {5'd26, 45'd0}, 4'd10, 1'b1, 20'd0, STATUS_BAD},
      '{OP_ADD, 50'd26, 4'd3, 1'b1, 20'd0, STATUS_BAD},
      // "a", then again with junk above its length
      '{OP_ADD, 50'd0, 4'd1, 1'b1, 20'd1, STATUS_OK},
      '{OP_ADD, {45'h1FFF_FFFF_FFFF, 5'd0}, 4'd1, 1'b1, 20'd2, STATUS_OK},
      // runs of a share bucket zero until it overflows
      '{OP_ADD, 50'd0, 4'd2, 1'b1, 20'd1, STATUS_OK},
      '{OP_ADD, 50'd0, 4'd3, 1'b1, 20'd1, STATUS_OK},
      '{OP_ADD, 50'd0, 4'd4, 1'b1, 20'd1, STATUS_OK},
      '{OP_ADD, 50'd0, 4'd5, 1'b1, 20'd0, STATUS_FULL},
      '{OP_QUERY, 50'd0, 4'd5, 1'b1, 20'd0, STATUS_OK},
      '{OP_QUERY, {40'hFF_FFFF_FFFF, 10'd0}, 4'd2, 1'b1, 20'd1, STATUS_OK},
      '{OP_QUERY, 50'd0, 4'd10, 1'b1, 20'd0, STATUS_OK},
      // longest word of the last letter
      '{OP_ADD, {10{5'd25}}, 4'd10, 1'b1, 20'd1, STATUS_OK},
      '{OP_QUERY, {10{5'd25}}, 4'd10, 1'b1, 20'd1, STATUS_OK},
      '{OP_ADD, {10{5'd25}}, 4'd10, 1'b1, 20'd2, STATUS_OK},
      '{OP_ADD, 50'd25, 4'd1, 1'b1, 20'd1, STATUS_OK},
      // bad letter past the length is ignored
      '{OP_ADD, {40'd0, 5'd26, 5'd1}, 4'd1, 1'b1, 20'd1, STATUS_OK},
      '{OP_ADD, {40'd0, 5'd1, 5'd0}, 4'd2, 1'b1, 20'd1, STATUS_OK},
      '{OP_QUERY, 50'd1, 4'd1, 1'b0, 20'd0, STATUS_OK}
   };

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_valid;
   logic                  req_stall;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic [COUNT_BITS-1:0] rsp_word_count;
   logic [STATUS_W-1:0]   rsp_status;
   stim_row_type          current_row;

   // predictor copy of the table
   logic [KEY_W-1:0]      tbl_key   [SLOTS];
   logic [COUNT_BITS-1:0] tbl_count [SLOTS];
   bit                    tbl_valid [SLOTS];

   count_result_type expected_counts [$];
   int            accepted_requests = 0;
   int            mismatches = 0;
   int            cycle_count = 0;
   int            burst_left = 0;

   word_count_hash_table u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_opcode       (current_row.opcode),
      .req_word_letters (current_row.word_letters),
      .req_word_length  (current_row.word_length),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_word_count   (rsp_word_count),
      .rsp_status       (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= REPORT_MAX)
         $display("mismatch at cycle %0d: %s", cycle_count, msg);
   endtask

   // hash the word, look up its bucket and apply the request to the table copy
   function automatic void predict_word_count(input stim_row_type row,
                                              output count_result_type res);
      longint unsigned     value;
      logic [WORD_W-1:0]   masked;
      logic [KEY_W-1:0]    key;
      logic [LETTER_W-1:0] letter;
      int                  k, w, slot, base, hit, free_slot;
      value = 0;
      masked = '0;
      hit = -1;
      free_slot = -1;
      res.word_count = '0;
      res.status = STATUS_BAD;
      if (row.word_length == 0 || row.word_length > MAX_LETTERS)
         return;
      for (k = 0; k < int'(row.word_length); k++) begin
         letter = row.word_letters[LETTER_W*k +: LETTER_W];
         if (letter >= ALPHABET)
            return;
         value = value * 26 + letter;
         masked[LETTER_W*k +: LETTER_W] = letter;
      end
      key = {row.word_length, masked};
      base = int'(value % BUCKETS) * WAYS;
      for (w = 0; w < WAYS; w++) begin
         slot = base + w;
         if (tbl_valid[slot]) begin
            if (hit < 0 && tbl_key[slot] == key)
               hit = slot;
         end else if (free_slot < 0) begin
            free_slot = slot;
         end
      end
      res.status = STATUS_OK;
      if (row.opcode == OP_QUERY) begin
         if (hit >= 0)
            res.word_count = tbl_count[hit];
      end else if (hit >= 0) begin
         if (tbl_count[hit] == COUNT_MAX) begin
            res.word_count = COUNT_MAX;
            res.status = STATUS_SAT;
         end else begin
            tbl_count[hit] = tbl_count[hit] + 1'b1;
            res.word_count = tbl_count[hit];
         end
      end else if (free_slot < 0) begin
         res.status = STATUS_FULL;
      end else begin
         tbl_valid[free_slot] = 1'b1;
         tbl_key[free_slot] = key;
         tbl_count[free_slot] = COUNT_BITS'(1);
         res.word_count = COUNT_BITS'(1);
      end
   endfunction

   // offer one request in bursts with random gaps, wait for its acceptance
   task automatic send_request(input stim_row_type row);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         if ($urandom_range(0, 3) != 0)
            gap = $urandom_range(1, 12);
      end
      burst_left--;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      current_row <= row;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   // request and response monitor
   always @(posedge clock) begin
      count_result_type head, predicted;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               report_mismatch($sformatf("response count %0d status %0d with none due",
                                         rsp_word_count, rsp_status));
            end else begin
               head = expected_counts.pop_front();
               if (rsp_word_count !== head.word_count)
                  report_mismatch($sformatf("word_count %0d, expected %0d",
                                            rsp_word_count, head.word_count));
               if (rsp_status !== head.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, head.status));
            end
         end
         if (req_valid && !req_stall) begin
            predict_word_count(current_row, predicted);
            if (current_row.pinned) begin
               predicted.word_count = current_row.exp_count;
               predicted.status = current_row.exp_status;
            end
            expected_counts.push_back(predicted);
            accepted_requests++;
         end
      end
   end

   // response stall: free, random and patterned stretches, one long hold-off
   initial begin
      rsp_mode_type stall_mode;
      int        mode_left, hold_left, phase;
      bit        hold_done;
      stall_mode = RSP_FREE;
      mode_left = 0;
      hold_left = 0;
      phase = 0;
      hold_done = 1'b0;
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (mode_left == 0) begin
            stall_mode = rsp_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         phase++;
         if (!hold_done && accepted_requests >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            case (stall_mode)
               RSP_FREE:    rsp_stall <= 1'b0;
               RSP_RANDOM:  rsp_stall <= ($urandom_range(0, 2) == 0);
               RSP_PATTERN: rsp_stall <= ((phase % 7) < 3);
               default:     rsp_stall <= 1'b0;
            endcase
         end
      end
   end

   // main sequence
   initial begin
      stim_row_type      row;
      logic [LETTER_W*3-1:0] base_word [POOL_SIZE];
      int                base_len [POOL_SIZE];
      logic [63:0]       junk;
      int                i, k, b, prefix, pick;
      reset <= 1'b1;
      req_valid <= 1'b0;
      current_row <= '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;

      // directed part
      for (i = 0; i < DIRECTED_N; i++)
         send_request(DIRECTED_ROWS[i]);

      // short stems; leading a's keep the hash, so prefixed forms share a bucket
      for (b = 0; b < POOL_SIZE; b++) begin
         base_len[b] = $urandom_range(1, 3);
         base_word[b] = '0;
         for (k = 0; k < base_len[b]; k++)
            base_word[b][LETTER_W*k +: LETTER_W] = LETTER_W'($urandom_range(0, 25));
      end

      // random part
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         junk = {$urandom(), $urandom()};
         row = '0;
         row.word_letters = junk[WORD_W-1:0];
         pick = $urandom_range(0, 99);
         if (pick < 70) begin
            // stem with a's in front: hits, inserts and full buckets
            b = $urandom_range(0, POOL_SIZE - 1);
            prefix = $urandom_range(0, MAX_LETTERS - base_len[b]);
            row.opcode = ($urandom_range(0, 4) == 0) ? OP_QUERY : OP_ADD;
            row.word_length = LEN_W'(prefix + base_len[b]);
            for (k = 0; k < prefix; k++)
               row.word_letters[LETTER_W*k +: LETTER_W] = '0;
            for (k = 0; k < base_len[b]; k++)
               row.word_letters[LETTER_W*(prefix+k) +: LETTER_W] =
                  base_word[b][LETTER_W*k +: LETTER_W];
         end else if (pick < 90) begin
            // any well-formed word
            row.opcode = ($urandom_range(0, 1) == 0) ? OP_QUERY : OP_ADD;
            row.word_length = LEN_W'($urandom_range(1, MAX_LETTERS));
            for (k = 0; k < int'(row.word_length); k++)
               row.word_letters[LETTER_W*k +: LETTER_W] = LETTER_W'($urandom_range(0, 25));
         end else begin
            // raw noise, mostly invalid
            row.opcode = ($urandom_range(0, 1) == 0) ? OP_QUERY : OP_ADD;
            row.word_length = LEN_W'($urandom_range(0, 15));
         end
         send_request(row);
      end

      // drain
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_counts.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end

endmodule

// ----- word_count_hash_table.f -----
src/wcht_pkg.sv
src/word_count_hash_table.sv
bench/tb.sv
